@@ rtl/line_comment_stripper_assert.svh @@
// Assertion macros shared by the line comment stripper modules
`ifndef LINE_COMMENT_STRIPPER_ASSERT_SVH
`define LINE_COMMENT_STRIPPER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LCS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lcs assertion failed");
`define LCS_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lcs forbidden condition");
`else
`define LCS_ASSERT(name, clk, rst_n, prop)
`define LCS_ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

@@ rtl/lcs_pkg.sv @@
// Package: types and constants of the line comment stripper
`timescale 1ns / 1ps
package lcs_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_TERM  = 8'h00;

    localparam int LINE_BITS   = 20;
    localparam int OFFSET_BITS = 24;

    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int LINE_WIDTH_DEF   = 20;

    localparam int CMD_FIFO_DEPTH = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_valid;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   first_on_line;
        logic [LINE_BITS-1:0]   line_number;
        logic [OFFSET_BITS-1:0] out_offset;
        logic                   final_result;
    } out_item_t;

    // One accepted item, reduced to what the back end must emit
    typedef struct packed {
        logic       has_slash;
        logic       slash_first;
        logic       has_main;
        logic [7:0] main_byte;
        logic       main_first;
        logic       line_inc;
        logic       term;
    } cmd_t;

endpackage

@@ rtl/line_comment_stripper.sv @@
// Top level: line comment stripper and whitespace collapser
// An accepted item's command is queued, and its results are registered in the output register.
// Throughput: one transaction per cycle while the queue is not full; k results leave one by one.
// The single output register sets the result rate; a two-entry command queue absorbs bursts.
// Reset (rst_n, async, active low): line count 1, offset 0, at line start, no comment.
// The same state is restored after each terminator, so a new text may follow at once.
`timescale 1ns / 1ps
module line_comment_stripper #(
    parameter int OFFSET_WIDTH = lcs_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = lcs_pkg::LINE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lcs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lcs_pkg::out_item_t out_data
);
    import lcs_pkg::*;

    logic cmd_push, cmd_full, cmd_pop, head_valid;
    cmd_t cmd_data, head_data;

    lcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_data)
    );

    lcs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (cmd_data),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    lcs_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (cmd_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

@@ rtl/lcs_front.sv @@
// Front end: accepts bytes, tracks line and comment state, issues commands
`timescale 1ns / 1ps
`include "line_comment_stripper_assert.svh"
module lcs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lcs_pkg::in_item_t in_data,
    input  logic            cmd_full,
    output logic            cmd_push,
    output lcs_pkg::cmd_t   cmd_data
);
    import lcs_pkg::*;

    logic at_line_start_reg, at_line_start_next;
    logic in_comment_reg, in_comment_next;
    logic prev_space_reg, prev_space_next;
    logic slash_held_reg, slash_held_next;
    logic accept;
    logic is_ws;
    cmd_t cmd;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;
    assign is_ws    = (in_data.in_byte == CH_SPACE) || (in_data.in_byte == CH_TAB)
                      || (in_data.in_byte == CH_CR);

    always_comb
    begin
        cmd                = '0;
        at_line_start_next = at_line_start_reg;
        in_comment_next    = in_comment_reg;
        prev_space_next    = prev_space_reg;
        slash_held_next    = slash_held_reg;
        if (in_data.byte_valid)
        begin
            if (in_data.in_byte == CH_NL)
            begin
                cmd.has_slash      = slash_held_reg;
                cmd.slash_first    = at_line_start_reg;
                cmd.has_main       = !at_line_start_reg || slash_held_reg;
                cmd.main_byte      = CH_NL;
                cmd.line_inc       = 1'b1;
                at_line_start_next = 1'b1;
                in_comment_next    = 1'b0;
                prev_space_next    = 1'b0;
                slash_held_next    = 1'b0;
            end
            else if (in_comment_reg)
            begin
                cmd = '0;
            end
            else if (in_data.in_byte == CH_SLASH)
            begin
                if (slash_held_reg)
                begin
                    slash_held_next = 1'b0;
                    in_comment_next = 1'b1;
                end
                else
                begin
                    slash_held_next = 1'b1;
                end
            end
            else
            begin
                if (slash_held_reg)
                begin
                    cmd.has_slash      = 1'b1;
                    cmd.slash_first    = at_line_start_reg;
                    slash_held_next    = 1'b0;
                    at_line_start_next = 1'b0;
                    prev_space_next    = 1'b0;
                end
                if (is_ws)
                begin
                    if (!at_line_start_next && !prev_space_next)
                    begin
                        cmd.has_main    = 1'b1;
                        cmd.main_byte   = CH_SPACE;
                        cmd.main_first  = 1'b0;
                        prev_space_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.has_main       = 1'b1;
                    cmd.main_byte      = in_data.in_byte;
                    cmd.main_first     = at_line_start_next;
                    at_line_start_next = 1'b0;
                    prev_space_next    = 1'b0;
                end
            end
        end
        if (in_data.end_of_text)
        begin
            if (slash_held_next)
            begin
                cmd.has_slash   = 1'b1;
                cmd.slash_first = at_line_start_next;
            end
            cmd.term           = 1'b1;
            at_line_start_next = 1'b1;
            in_comment_next    = 1'b0;
            prev_space_next    = 1'b0;
            slash_held_next    = 1'b0;
        end
    end

    assign cmd_data = cmd;
    assign cmd_push = accept && (cmd.has_slash || cmd.has_main || cmd.line_inc || cmd.term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            in_comment_reg    <= 1'b0;
            prev_space_reg    <= 1'b0;
            slash_held_reg    <= 1'b0;
        end
        else if (accept)
        begin
            at_line_start_reg <= at_line_start_next;
            in_comment_reg    <= in_comment_next;
            prev_space_reg    <= prev_space_next;
            slash_held_reg    <= slash_held_next;
        end
    end

    `LCS_ASSERT_NEVER(a_comment_no_slash, clk, rst_n, in_comment_reg && slash_held_reg)

endmodule

@@ rtl/lcs_fifo.sv @@
// Command queue between front and back ends
`timescale 1ns / 1ps
`include "line_comment_stripper_assert.svh"
module lcs_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lcs_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output lcs_pkg::cmd_t head_data
);
    import lcs_pkg::*;

    localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             entry_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `LCS_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full)

endmodule

@@ rtl/lcs_back.sv @@
// Back end: expands commands into result transactions, owns line and offset counters
`timescale 1ns / 1ps
`include "line_comment_stripper_assert.svh"
module lcs_back #(
    parameter int OFFSET_WIDTH = lcs_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = lcs_pkg::LINE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  lcs_pkg::cmd_t     head_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output lcs_pkg::out_item_t out_data
);
    import lcs_pkg::*;

    logic [LINE_WIDTH-1:0]   line_reg, line_next, line_inc_val;
    logic [OFFSET_WIDTH-1:0] written_reg, written_next;
    logic                    slash_done_reg, slash_done_next;
    logic                    main_done_reg, main_done_next;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;
    logic                    out_free;
    logic                    pend_slash, pend_main;
    logic                    emit, emit_term, do_inc, do_clr;
    logic [7:0]              emit_byte;
    logic                    emit_first;
    logic [LINE_WIDTH-1:0]   emit_line;
    logic [LINE_WIDTH+LINE_BITS-1:0]     line_ext;
    logic [OFFSET_WIDTH+OFFSET_BITS-1:0] offset_ext;

    assign out_free     = !out_valid_reg || out_ready;
    assign pend_slash   = head_data.has_slash && !slash_done_reg;
    assign pend_main    = head_data.has_main && !main_done_reg;
    assign line_inc_val = (head_data.line_inc && (line_reg != '1)) ? line_reg + 1'b1 : line_reg;

    always_comb
    begin
        pop             = 1'b0;
        emit            = 1'b0;
        emit_term       = 1'b0;
        emit_byte       = CH_TERM;
        emit_first      = 1'b0;
        emit_line       = line_reg;
        do_inc          = 1'b0;
        do_clr          = 1'b0;
        slash_done_next = slash_done_reg;
        main_done_next  = main_done_reg;
        if (head_valid)
        begin
            if (pend_slash)
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = CH_SLASH;
                    emit_first = head_data.slash_first;
                    if (head_data.has_main || head_data.term)
                    begin
                        slash_done_next = 1'b1;
                    end
                    else
                    begin
                        pop    = 1'b1;
                        do_inc = 1'b1;
                    end
                end
            end
            else if (pend_main)
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = head_data.main_byte;
                    emit_first = head_data.main_first;
                    if (head_data.term)
                    begin
                        main_done_next = 1'b1;
                    end
                    else
                    begin
                        pop    = 1'b1;
                        do_inc = 1'b1;
                    end
                end
            end
            else if (head_data.term)
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_term = 1'b1;
                    emit_line = line_inc_val;
                    pop       = 1'b1;
                    do_clr    = 1'b1;
                end
            end
            else
            begin
                pop    = 1'b1;
                do_inc = 1'b1;
            end
        end
        if (pop)
        begin
            slash_done_next = 1'b0;
            main_done_next  = 1'b0;
        end
    end

    always_comb
    begin
        written_next = written_reg;
        line_next    = line_reg;
        if (emit && (written_reg != '1))
        begin
            written_next = written_reg + 1'b1;
        end
        if (do_inc)
        begin
            line_next = line_inc_val;
        end
        if (do_clr)
        begin
            written_next = '0;
            line_next    = LINE_WIDTH'(1);
        end
    end

    assign line_ext   = {{LINE_BITS{1'b0}}, emit_line};
    assign offset_ext = {{OFFSET_BITS{1'b0}}, written_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg       <= LINE_WIDTH'(1);
            written_reg    <= '0;
            slash_done_reg <= 1'b0;
            main_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_reg       <= line_next;
            written_reg    <= written_next;
            slash_done_reg <= slash_done_next;
            main_done_reg  <= main_done_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && emit)
        begin
            out_data_reg.out_byte      <= emit_byte;
            out_data_reg.first_on_line <= emit_first;
            out_data_reg.line_number   <= line_ext[LINE_BITS-1:0];
            out_data_reg.out_offset    <= offset_ext[OFFSET_BITS-1:0];
            out_data_reg.final_result  <= emit_term;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LCS_ASSERT(a_term_clears_counters, clk, rst_n, emit_term |=> ((line_reg == LINE_WIDTH'(1)) && (written_reg == '0)))
    `LCS_ASSERT(a_done_needs_head, clk, rst_n, (slash_done_reg || main_done_reg) |-> head_valid)

endmodule

@@ tb/line_comment_stripper_test.sv @@
// Testbench for line_comment_stripper: directed table, random texts, stalled closing text
`timescale 1ns / 1ps
module line_comment_stripper_test;
    import lcs_pkg::*;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        out_item_t want;
    } row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    int gap_pct = 0;
    int stall_pct = 0;
    int errors = 0;

    // cleaned bytes still owed by the block, oldest first
    out_item_t pending[$];
    out_item_t want_item;

    // shadow copy of the stripper state
    logic [LINE_BITS-1:0]   line_no;
    logic [OFFSET_BITS-1:0] out_pos;
    bit line_start;
    bit in_cmt;
    bit last_space;
    bit slash_hold;

    row_t script [0:24] = '{
        '{'{CH_TERM, 1'b0, 1'b1}, 1'b1, '{CH_TERM, 1'b0, 20'd1, 24'd0, 1'b1}},
        '{'{8'h41, 1'b1, 1'b0}, 1'b1, '{8'h41, 1'b1, 20'd1, 24'd0, 1'b0}},
        '{'{8'hFF, 1'b1, 1'b0}, 1'b1, '{8'hFF, 1'b0, 20'd1, 24'd1, 1'b0}},
        '{'{8'h5A, 1'b0, 1'b0}, 1'b0, '0},
        '{'{CH_TERM, 1'b0, 1'b1}, 1'b1, '{CH_TERM, 1'b0, 20'd1, 24'd2, 1'b1}},
        '{'{CH_SPACE, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_TAB, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h78, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_CR, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SPACE, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SLASH, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h79, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SLASH, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SLASH, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h7A, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_NL, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_NL, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SLASH, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SLASH, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_NL, 1'b1, 1'b0}, 1'b0, '0},
        '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SPACE, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SLASH, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_NL, 1'b1, 1'b0}, 1'b0, '0},
        '{'{CH_SLASH, 1'b1, 1'b1}, 1'b0, '0}
    };

    line_comment_stripper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    task automatic clear_text();
        line_no    = LINE_BITS'(1);
        out_pos    = '0;
        line_start = 1'b1;
        in_cmt     = 1'b0;
        last_space = 1'b0;
        slash_hold = 1'b0;
    endtask

    task automatic put_byte(logic [7:0] b, bit first, bit fin);
        pending.push_back('{b, first, line_no, out_pos, fin});
        if (out_pos != '1)
            out_pos++;
    endtask

    task automatic put_text_byte(logic [7:0] b);
        put_byte(b, line_start, 1'b0);
        line_start = 1'b0;
    endtask

    task automatic release_slash();
        if (slash_hold)
        begin
            slash_hold = 1'b0;
            put_text_byte(CH_SLASH);
            last_space = 1'b0;
        end
    endtask

    task automatic strip_predict(in_item_t it);
        logic [7:0] c;
        bit ws;
        c = it.in_byte;
        ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
        if (it.byte_valid)
        begin
            if (c == CH_NL)
            begin
                release_slash();
                if (!line_start)
                    put_byte(CH_NL, 1'b0, 1'b0);
                if (line_no != '1)
                    line_no++;
                line_start = 1'b1;
                in_cmt     = 1'b0;
                last_space = 1'b0;
            end
            else if (in_cmt)
            begin
            end
            else if (c == CH_SLASH)
            begin
                if (slash_hold)
                begin
                    slash_hold = 1'b0;
                    in_cmt     = 1'b1;
                end
                else
                    slash_hold = 1'b1;
            end
            else
            begin
                release_slash();
                if (ws)
                begin
                    if (!line_start && !last_space)
                    begin
                        put_byte(CH_SPACE, 1'b0, 1'b0);
                        last_space = 1'b1;
                    end
                end
                else
                begin
                    put_text_byte(c);
                    last_space = 1'b0;
                end
            end
        end
        if (it.end_of_text)
        begin
            release_slash();
            put_byte(CH_TERM, 1'b0, 1'b1);
            clear_text();
        end
    endtask

    // offer one transaction, wait for it to be taken, then record what it should produce
    task automatic send_byte(in_item_t it, bit fixed, out_item_t want);
        int depth;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        depth = pending.size();
        strip_predict(it);
        if (fixed)
        begin
            while (pending.size() > depth)
                pending.delete(pending.size() - 1);
            pending.push_back(want);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending.size() != 0);
    endtask

    function automatic in_item_t random_byte();
        in_item_t it;
        int pick;
        pick = $urandom_range(99);
        it.byte_valid  = 1'b1;
        it.end_of_text = ($urandom_range(99) < 4);
        if (pick < 22)
            it.in_byte = 8'h61 + 8'($urandom_range(25));
        else if (pick < 27)
            it.in_byte = CH_SPACE;
        else if (pick < 32)
            it.in_byte = CH_TAB;
        else if (pick < 36)
            it.in_byte = CH_CR;
        else if (pick < 48)
            it.in_byte = CH_NL;
        else if (pick < 64)
            it.in_byte = CH_SLASH;
        else if (pick < 92)
            it.in_byte = 8'($urandom_range(255));
        else
        begin
            it.in_byte    = 8'($urandom_range(255));
            it.byte_valid = 1'b0;
        end
        return it;
    endfunction

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t unexpected transaction: byte=%h first=%b line=%0d offset=%0d final=%b",
                    $time, out_data.out_byte, out_data.first_on_line, out_data.line_number,
                    out_data.out_offset, out_data.final_result);
            end
            else
            begin
                want_item = pending.pop_front();
                if (out_data.out_byte !== want_item.out_byte
                    || out_data.first_on_line !== want_item.first_on_line
                    || out_data.line_number !== want_item.line_number
                    || out_data.out_offset !== want_item.out_offset
                    || out_data.final_result !== want_item.final_result)
                begin
                    errors++;
                    $display("%0t mismatch: expected byte=%h first=%b line=%0d offset=%0d final=%b",
                        $time, want_item.out_byte, want_item.first_on_line,
                        want_item.line_number, want_item.out_offset, want_item.final_result);
                    $display("%0t           actual   byte=%h first=%b line=%0d offset=%0d final=%b",
                        $time, out_data.out_byte, out_data.first_on_line,
                        out_data.line_number, out_data.out_offset, out_data.final_result);
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int gaps [4];
        int stalls [4];
        in_item_t it;
        gaps   = '{0, 49, 0, 35};
        stalls = '{0, 0, 49, 35};
        clear_text();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 25; i++)
            send_byte(script[i].item, script[i].fixed, script[i].want);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            gap_pct   = gaps[p];
            stall_pct = stalls[p];
            for (int i = 0; i < 125; i++)
                send_byte(random_byte(), 1'b0, '0);
            drain_results();
        end

        // close any open text, then a short text under output stalls
        gap_pct   = 0;
        stall_pct = 0;
        send_byte('{CH_TERM, 1'b0, 1'b1}, 1'b0, '0);
        stall_pct = 35;
        send_byte('{8'h71, 1'b1, 1'b0}, 1'b0, '0);
        send_byte('{CH_NL, 1'b1, 1'b0}, 1'b0, '0);
        send_byte('{8'h72, 1'b1, 1'b0}, 1'b0, '0);
        it = '{CH_SLASH, 1'b1, 1'b1};
        send_byte(it, 1'b0, '0);

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
